### src/srfa_pkg.sv
package srfa_pkg;

    localparam int STORE_DEPTH_DEF = 64;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 6;
    localparam int CAUSE_W   = 2;
    localparam int IDLE_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [IDLE_W-1:0] DEFAULT_TIMEOUT = IDLE_W'(10);

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic MODE_TIMEOUT = 1'b0;
    localparam logic MODE_END     = 1'b1;

    localparam logic [CAUSE_W-1:0] CAUSE_FULL    = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_END     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd2;

    typedef struct packed {
        logic              item_kind;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_byte;
        logic [POS_W-1:0]   byte_position;
        logic [POS_W-1:0]   frame_length;
        logic [CAUSE_W-1:0] close_cause;
        logic               last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] wr_data;
    } t_cfg_wr;

endpackage

### src/srfa_ifs.sv
interface srfa_in_if;
    logic               valid;
    logic               ready;
    srfa_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srfa_out_if;
    logic                valid;
    logic                ready;
    srfa_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srfa_cfg_if;
    logic              valid;
    logic              ready;
    srfa_pkg::t_cfg_wr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/srfa_ram.sv
module srfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

### src/serial_receive_frame_assembler.sv
// Serial receive frame assembler.
// i_in carries one transaction per received byte or per elapsed time tick.
// Bytes are written into a frame store; a frame closes when the store holds
// STORE_DEPTH-1 bytes, when a tick finds the idle count above timeout_ticks
// (10 if timeout_ticks is 0; timeout mode), or when the end byte arrives (end-byte mode).
// o_out then carries one transaction per stored byte, in arrival order, with
// position, frame length, close cause and a last flag.
// i_cfg writes frame_mode (0), timeout_ticks (1) and end_byte (2); other
// indexes are dropped. It is always ready.
// Throughput: one input transaction a cycle while no frame closes. A closing
// transaction holds off i_in until every stored byte is read out: each byte goes
// through S_READ (store read address) and S_LOAD (registered store read into the
// output register), so no new input is taken during the readout.
// When the receiver stalls, the readout waits on the output register; input
// is taken again once the last result sits in that register.
// Reset (synchronous) clears fill count, open flag, idle count and readout
// control and sets the registers to 0 / 10 / 10. The store is not cleared.
module serial_receive_frame_assembler #(
    parameter int STORE_DEPTH = srfa_pkg::STORE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    srfa_in_if.sink           i_in,
    srfa_out_if.source        o_out,
    srfa_cfg_if.sink          i_cfg
);

    import srfa_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [AW-1:0]        r_fill, n_fill;
    logic                 r_open, n_open;
    logic [IDLE_W-1:0]    r_idle, n_idle;
    logic [AW-1:0]        r_len, n_len;
    logic [CAUSE_W-1:0]   r_cause, n_cause;
    logic [AW-1:0]        r_rd_idx, n_rd_idx;
    t_out_item            r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 r_mode;
    logic [IDLE_W-1:0]    r_timeout;
    logic [BYTE_W-1:0]    r_end_byte;

    logic                 w_in_acc;
    logic                 w_wr_en;
    logic [BYTE_W-1:0]    w_rd_data;
    logic [IDLE_W-1:0]    w_limit;
    logic [IDLE_W-1:0]    w_idle_inc;
    logic                 w_last;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid & i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_wr_en    = w_in_acc && (i_in.data.item_kind == KIND_BYTE);
    assign w_limit    = (r_timeout == '0) ? DEFAULT_TIMEOUT : r_timeout;
    assign w_idle_inc = (r_idle == '1) ? r_idle : r_idle + 1'b1;
    assign w_last     = (r_rd_idx == r_len - 1'b1);

    srfa_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (i_in.data.rx_byte),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_open      = r_open;
        n_idle      = r_idle;
        n_len       = r_len;
        n_cause     = r_cause;
        n_rd_idx    = r_rd_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.data.item_kind == KIND_BYTE) begin
                        n_open = 1'b1;
                        n_idle = '0;
                        n_fill = r_fill + 1'b1;
                        if (r_fill == AW'(STORE_DEPTH - 2)) begin
                            n_cause = CAUSE_FULL;
                            n_state = S_READ;
                        end else if (r_mode == MODE_END
                                     && i_in.data.rx_byte == r_end_byte) begin
                            n_cause = CAUSE_END;
                            n_state = S_READ;
                        end
                    end else if (r_open) begin
                        n_idle = w_idle_inc;
                        if (r_mode == MODE_TIMEOUT && w_idle_inc > w_limit) begin
                            n_cause = CAUSE_TIMEOUT;
                            n_state = S_READ;
                        end
                    end
                    if (n_state == S_READ) begin
                        n_len    = n_fill;
                        n_fill   = '0;
                        n_open   = 1'b0;
                        n_rd_idx = '0;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid         = 1'b1;
                    n_out.frame_byte    = w_rd_data;
                    n_out.byte_position = POS_W'(r_rd_idx);
                    n_out.frame_length  = POS_W'(r_len);
                    n_out.close_cause   = r_cause;
                    n_out.last_of_frame = w_last;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                        n_state  = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_open      <= 1'b0;
            r_idle      <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
            r_len       <= '0;
            r_cause     <= CAUSE_FULL;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_open      <= n_open;
            r_idle      <= n_idle;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
            r_len       <= n_len;
            r_cause     <= n_cause;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_TIMEOUT;
            r_timeout  <= DEFAULT_TIMEOUT;
            r_end_byte <= BYTE_W'(10);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.data.index)
                CFG_FRAME_MODE: r_mode     <= i_cfg.data.wr_data[0];
                CFG_TIMEOUT:    r_timeout  <= i_cfg.data.wr_data[IDLE_W-1:0];
                CFG_END_BYTE:   r_end_byte <= i_cfg.data.wr_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // closed frame never empty, store never fills past its limit
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_len != '0))
        else $error("readout of an empty frame");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= AW'(STORE_DEPTH - 2))
        else $error("fill count past store limit");

    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_fill == '0))
        else $error("bytes held with no open frame");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.byte_position < r_out.frame_length))
        else $error("byte position beyond frame length");

    a_readout_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_READ) |=> (r_rd_idx == '0 && r_fill == '0))
        else $error("readout did not restart at first byte");

endmodule

### bench/tb_serial_receive_frame_assembler.sv
`timescale 1ns / 100ps

module tb_serial_receive_frame_assembler;
    import srfa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEM_BUDGET = 160;

    class frame_scoreboard;
        logic [BYTE_W-1:0] held_bytes [STORE_DEPTH_DEF];
        int                fill;
        bit                frame_open;
        logic [IDLE_W-1:0] idle_count;
        logic              mode_cfg;
        logic [IDLE_W-1:0] timeout_cfg;
        logic [BYTE_W-1:0] end_cfg;
        t_out_item         pending_bytes [$];
        int                frames_closed;
        int                frames_by_cause [3];
        int                bytes_checked;
        int                mismatches;

        function new();
            fill = 0;
            frame_open = 1'b0;
            idle_count = '0;
            mode_cfg = MODE_TIMEOUT;
            timeout_cfg = DEFAULT_TIMEOUT;
            end_cfg = 8'd10;
            frames_closed = 0;
            frames_by_cause = '{0, 0, 0};
            bytes_checked = 0;
            mismatches = 0;
        endfunction

        function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_FRAME_MODE: mode_cfg = val[0];
                CFG_TIMEOUT:    timeout_cfg = val[IDLE_W-1:0];
                CFG_END_BYTE:   end_cfg = val[BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        function void close_frame(logic [CAUSE_W-1:0] cause);
            t_out_item r;
            for (int k = 0; k < fill; k++) begin
                r.frame_byte    = held_bytes[k];
                r.byte_position = POS_W'(k);
                r.frame_length  = POS_W'(fill);
                r.close_cause   = cause;
                r.last_of_frame = (k == fill - 1);
                pending_bytes.push_back(r);
            end
            frames_closed++;
            frames_by_cause[cause]++;
            fill = 0;
            frame_open = 1'b0;
        endfunction

        // returns 0 for a tick that finds no open frame
        function bit absorb_item(t_in_item it);
            logic [IDLE_W-1:0] limit;
            if (it.item_kind == KIND_BYTE) begin
                frame_open = 1'b1;
                idle_count = '0;
                if (fill < STORE_DEPTH_DEF) begin
                    held_bytes[fill] = it.rx_byte;
                    fill++;
                end
                if (fill >= STORE_DEPTH_DEF - 1)
                    close_frame(CAUSE_FULL);
                else if (mode_cfg == MODE_END && it.rx_byte == end_cfg)
                    close_frame(CAUSE_END);
                return 1'b1;
            end
            if (!frame_open)
                return 1'b0;
            if (idle_count != '1)
                idle_count++;
            limit = (timeout_cfg == '0) ? DEFAULT_TIMEOUT : timeout_cfg;
            if (mode_cfg == MODE_TIMEOUT && idle_count > limit)
                close_frame(CAUSE_TIMEOUT);
            return 1'b1;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_readout(t_out_item got);
            t_out_item want;
            if (pending_bytes.size() == 0) begin
                $error("frame_byte: expected none, got %0d", got.frame_byte);
                mismatches++;
                return;
            end
            want = pending_bytes.pop_front();
            bytes_checked++;
            compare_field("frame_byte", want.frame_byte, got.frame_byte);
            compare_field("byte_position", want.byte_position, got.byte_position);
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("close_cause", want.close_cause, got.close_cause);
            compare_field("last_of_frame", want.last_of_frame, got.last_of_frame);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    srfa_in_if  in_if ();
    srfa_out_if out_if ();
    srfa_cfg_if cfg_if ();

    serial_receive_frame_assembler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    frame_scoreboard sb;
    bit gaps_on;
    int burst_left;
    int items_taken;
    int items_live;
    int reg_writes;
    int stall_style;
    int stall_cycles;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (stall_cycles == 0) begin
            stall_style  <= $urandom_range(0, 3);
            stall_cycles <= $urandom_range(16, 80);
        end else begin
            stall_cycles <= stall_cycles - 1;
        end
        case (stall_style)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ~out_if.ready;
            2: out_if.ready <= 1'($urandom);
            default: out_if.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_readout(out_if.data);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("serial_receive_frame_assembler: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_item(logic kind, logic [BYTE_W-1:0] value);
        t_in_item it;
        it.item_kind = kind;
        it.rx_byte   = value;
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        items_taken++;
        if (sb.absorb_item(it))
            items_live++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        t_cfg_wr w;
        w.index   = idx;
        w.wr_data = val;
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= w;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.apply_reg_write(idx, val);
        reg_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    // wait for the readout to finish before touching the registers
    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic tick_until_close();
        int closes;
        closes = sb.frames_closed;
        while (sb.frames_closed == closes && sb.frame_open)
            push_item(KIND_TICK, 8'($urandom));
    endtask

    task automatic run_random_frame();
        int pick;
        int n;
        int closes;
        int limit;
        logic [BYTE_W-1:0] b;
        pick = $urandom_range(0, 11);
        closes = sb.frames_closed;
        limit = (sb.timeout_cfg == '0) ? int'(DEFAULT_TIMEOUT) : int'(sb.timeout_cfg);
        if (limit > 10)
            limit = 10;
        if (pick == 0) begin
            for (int k = 0; k < STORE_DEPTH_DEF && sb.frames_closed == closes; k++)
                push_item(KIND_BYTE, 8'($urandom));
        end else if (pick == 1) begin
            repeat ($urandom_range(2, 6)) push_item(1'($urandom), 8'($urandom));
        end else begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n && sb.frames_closed == closes; k++) begin
                b = 8'($urandom);
                if (sb.mode_cfg == MODE_END) begin
                    if (k == n - 1)
                        b = sb.end_cfg;
                    else if (b == sb.end_cfg)
                        b = ~b;
                end
                push_item(KIND_BYTE, b);
                if (k != n - 1)
                    repeat ($urandom_range(0, limit)) push_item(KIND_TICK, 8'($urandom));
            end
            if (sb.mode_cfg == MODE_TIMEOUT)
                tick_until_close();
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] b;
        sb = new();
        gaps_on = 1'b1;
        burst_left = 0;
        items_taken = 0;
        items_live = 0;
        reg_writes = 0;
        stall_style = 0;
        stall_cycles = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: idle timeout of 10, a stray tick first
        push_item(KIND_TICK, 8'hFF);
        push_item(KIND_BYTE, 8'h00);
        push_item(KIND_BYTE, 8'hFF);
        push_item(KIND_BYTE, 8'd10);
        tick_until_close();

        // end byte mode, ticks must not close
        settle();
        write_reg(CFG_FRAME_MODE, {15'h7FFF, MODE_END});
        write_reg(CFG_END_BYTE, 16'hAB00);
        write_reg(CFG_TIMEOUT, 16'h0000);
        write_reg(CFG_UNUSED, 16'hFFFF);
        push_item(KIND_BYTE, 8'h80);
        push_item(KIND_BYTE, 8'h7F);
        push_item(KIND_TICK, 8'h00);
        push_item(KIND_TICK, 8'h55);
        push_item(KIND_BYTE, 8'h00);
        settle();
        write_reg(CFG_END_BYTE, 16'h00FF);
        push_item(KIND_BYTE, 8'hFF);

        // zero timeout behaves as 10
        settle();
        write_reg(CFG_FRAME_MODE, {15'h0000, MODE_TIMEOUT});
        push_item(KIND_BYTE, 8'h5A);
        tick_until_close();

        // mode switched while a frame is open
        settle();
        write_reg(CFG_FRAME_MODE, {15'h0000, MODE_END});
        write_reg(CFG_END_BYTE, 16'h0022);
        push_item(KIND_BYTE, 8'h11);
        repeat (3) push_item(KIND_TICK, 8'h00);
        settle();
        write_reg(CFG_TIMEOUT, 16'd2);
        write_reg(CFG_FRAME_MODE, {15'h0000, MODE_TIMEOUT});
        push_item(KIND_TICK, 8'h00);

        // store full with the end byte last: full wins
        settle();
        write_reg(CFG_FRAME_MODE, {15'h0000, MODE_END});
        write_reg(CFG_END_BYTE, 16'h007E);
        repeat (STORE_DEPTH_DEF - 2) begin
            b = 8'($urandom);
            push_item(KIND_BYTE, (b == 8'h7E) ? 8'h7F : b);
        end
        push_item(KIND_BYTE, 8'h7E);

        // largest timeout holds the frame open through an idle spell
        settle();
        write_reg(CFG_FRAME_MODE, {15'h0000, MODE_TIMEOUT});
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        push_item(KIND_BYTE, 8'hC3);
        repeat (12) push_item(KIND_TICK, 8'($urandom));
        settle();
        write_reg(CFG_TIMEOUT, 16'd4);
        push_item(KIND_TICK, 8'h00);

        while (items_taken < ITEM_BUDGET) begin
            settle();
            gaps_on = ($urandom_range(0, 3) != 0);
            write_reg(CFG_TIMEOUT, 16'($urandom_range(0, 6)));
            if ($urandom_range(0, 1))
                write_reg(CFG_FRAME_MODE, 16'($urandom));
            if ($urandom_range(0, 1))
                write_reg(CFG_END_BYTE, 16'($urandom));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED, 16'($urandom));
            repeat ($urandom_range(1, 4)) run_random_frame();
        end

        in_if.valid <= 1'b0;
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_bytes.size() != 0) begin
            $error("frame_byte: %0d readout bytes never arrived", sb.pending_bytes.size());
            sb.mismatches++;
        end

        $display("run: %0d input transactions (%0d live), %0d register writes, %0d frames",
                 items_taken, items_live, reg_writes, sb.frames_closed);
        $display("causes full/timeout/end byte %0d/%0d/%0d, %0d readout bytes checked",
                 sb.frames_by_cause[CAUSE_FULL], sb.frames_by_cause[CAUSE_TIMEOUT],
                 sb.frames_by_cause[CAUSE_END], sb.bytes_checked);
        if (sb.mismatches == 0) begin
            $display("serial_receive_frame_assembler: match");
        end else begin
            $display("serial_receive_frame_assembler: mismatch");
        end
        $finish;
    end

endmodule
